// ===== design/aesd_pkg.sv =====
// ---------------------------------------------------------------------------
// AES-128 decrypt package
// Shared types, tables and round functions for the inverse cipher pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
package aesd_pkg;

   localparam int unsigned NumRounds = 10;
   localparam int unsigned BlockBits = 128;
   localparam int unsigned CsrIdxBits = 8;

   typedef logic [BlockBits-1:0] block_type;
   typedef logic [CsrIdxBits-1:0] csr_idx_type;

   localparam csr_idx_type CsrKeyUpper = csr_idx_type'(0);
   localparam csr_idx_type CsrKeyLower = csr_idx_type'(1);

   localparam logic [0:255][7:0] Sbox = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

   localparam logic [0:255][7:0] InvSbox = {
      128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

   function automatic logic [7:0] get_byte(input block_type s, input int unsigned i);
      get_byte = s[BlockBits-1-8*i -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Multiply by 9, 11, 13, 14 from shared doublings.
   function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
      logic [7:0] a [4];
      logic [7:0] a2 [4];
      logic [7:0] a4 [4];
      logic [7:0] a8 [4];
      logic [7:0] m9 [4];
      logic [7:0] m11 [4];
      logic [7:0] m13 [4];
      logic [7:0] m14 [4];
      for (int r = 0; r < 4; r++) begin
         a[r] = c[31-8*r -: 8];
         a2[r] = xtime(a[r]);
         a4[r] = xtime(a2[r]);
         a8[r] = xtime(a4[r]);
         m9[r] = a8[r] ^ a[r];
         m11[r] = a8[r] ^ a2[r] ^ a[r];
         m13[r] = a8[r] ^ a4[r] ^ a[r];
         m14[r] = a8[r] ^ a4[r] ^ a2[r];
      end
      inv_mix_col = {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
                     m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
                     m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
                     m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
   endfunction

   function automatic block_type inv_round(input block_type s, input block_type rk,
                                           input logic mix);
      block_type t;
      block_type r;
      for (int c = 0; c < 4; c++) begin
         for (int w = 0; w < 4; w++) begin
            t[BlockBits-1-8*(w+4*c) -: 8] = InvSbox[get_byte(s, w + 4*((c - w + 4) % 4))];
         end
      end
      t = t ^ rk;
      r = t;
      if (mix) begin
         for (int c = 0; c < 4; c++) begin
            r[BlockBits-1-32*c -: 32] = inv_mix_col(t[BlockBits-1-32*c -: 32]);
         end
      end
      inv_round = r;
   endfunction

   function automatic block_type next_round_key(input block_type k, input logic [7:0] rcon);
      logic [31:0] w [4];
      logic [31:0] t;
      block_type n;
      for (int i = 0; i < 4; i++) w[i] = k[BlockBits-1-32*i -: 32];
      t = {w[3][23:0], w[3][31:24]};
      t = {Sbox[t[31:24]] ^ rcon, Sbox[t[23:16]], Sbox[t[15:8]], Sbox[t[7:0]]};
      w[0] = w[0] ^ t;
      w[1] = w[1] ^ w[0];
      w[2] = w[2] ^ w[1];
      w[3] = w[3] ^ w[2];
      n = {w[0], w[1], w[2], w[3]};
      next_round_key = n;
   endfunction

endpackage
`default_nettype wire

// ===== design/aesd_if.sv =====
// ---------------------------------------------------------------------------
// AES-128 decrypt channels
// Valid/ready channels for ciphertext, plaintext and key register writes.
// ---------------------------------------------------------------------------
`default_nettype none
interface aesd_req_if;
   logic valid;
   logic ready;
   logic [63:0] cipher_upper;
   logic [63:0] cipher_lower;
   modport source (output valid, cipher_upper, cipher_lower, input ready);
   modport sink (input valid, cipher_upper, cipher_lower, output ready);
endinterface

interface aesd_rsp_if;
   logic valid;
   logic ready;
   logic [63:0] plain_upper;
   logic [63:0] plain_lower;
   modport source (output valid, plain_upper, plain_lower, input ready);
   modport sink (input valid, plain_upper, plain_lower, output ready);
endinterface

interface aesd_csr_if;
   logic valid;
   logic ready;
   aesd_pkg::csr_idx_type index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/aes128_block_decrypt.sv =====
// ---------------------------------------------------------------------------
// AES-128 block decrypt
// Eleven-stage inverse cipher pipeline with on-chip round key schedule.
// ---------------------------------------------------------------------------
// One ciphertext block enters per cycle while the output is not stalled and no
// key schedule runs; it passes one register stage per round plus the initial
// key add. Round keys are held in registers and rebuilt after reset and after
// every key write by a schedule unit that makes one round key per cycle; while
// it runs no block is accepted. Key writes are taken at any time, but write keys
// only while no block is in flight.
`default_nettype none
module aes128_block_decrypt (
   input wire logic clock,
   input wire logic reset,
   aesd_req_if.sink req_chan,
   aesd_rsp_if.source rsp_chan,
   aesd_csr_if.sink csr_chan
);
   localparam int unsigned NR = aesd_pkg::NumRounds;

   logic [63:0] key_upper_ff, key_lower_ff;
   logic pend_ff, busy_ff;
   logic [3:0] cnt_ff;
   logic [7:0] rcon_ff;
   aesd_pkg::block_type kw_ff, kw_in;
   aesd_pkg::block_type rk_ff [NR+1];

   logic vld_ff [NR+1];
   aesd_pkg::block_type st_ff [NR+1];
   logic en, req_fire, csr_fire;

   assign csr_chan.ready = 1'b1;
   assign csr_fire = csr_chan.valid;
   assign en = !vld_ff[NR] || rsp_chan.ready;
   assign req_chan.ready = en && !busy_ff && !pend_ff;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign kw_in = aesd_pkg::next_round_key(kw_ff, rcon_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff <= '0;
         key_lower_ff <= '0;
      end else if (csr_fire) begin
         if (csr_chan.index == aesd_pkg::CsrKeyUpper) key_upper_ff <= csr_chan.data;
         if (csr_chan.index == aesd_pkg::CsrKeyLower) key_lower_ff <= csr_chan.data;
      end
   end

   // Key schedule: load, then one round key per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b1;
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (csr_fire) begin
         pend_ff <= 1'b1;
         busy_ff <= 1'b0;
      end else if (pend_ff) begin
         pend_ff <= 1'b0;
         busy_ff <= 1'b1;
         cnt_ff <= 4'd1;
      end else if (busy_ff) begin
         if (cnt_ff == 4'(NR)) busy_ff <= 1'b0;
         else cnt_ff <= cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         kw_ff <= {key_upper_ff, key_lower_ff};
         rk_ff[0] <= {key_upper_ff, key_lower_ff};
         rcon_ff <= 8'h01;
      end else if (busy_ff) begin
         kw_ff <= kw_in;
         rk_ff[cnt_ff] <= kw_in;
         rcon_ff <= aesd_pkg::xtime(rcon_ff);
      end
   end

   // Round pipeline; all stages advance together.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NR; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_fire;
         for (int i = 1; i <= NR; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= {req_chan.cipher_upper, req_chan.cipher_lower} ^ rk_ff[NR];
         for (int i = 1; i <= NR; i++) begin
            st_ff[i] <= aesd_pkg::inv_round(st_ff[i-1], rk_ff[NR-i], i != NR);
         end
      end
   end

   assign rsp_chan.valid = vld_ff[NR];
   assign rsp_chan.plain_upper = st_ff[NR][127:64];
   assign rsp_chan.plain_lower = st_ff[NR][63:0];

   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      (busy_ff || pend_ff) |-> !req_chan.ready) else $error("block taken during key schedule");
   a_csr_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_fire |=> pend_ff) else $error("key write did not restart schedule");
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> vld_ff[0]) else $error("accepted block lost at entry");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=> rsp_chan.valid && $stable(st_ff[NR]))
      else $error("result changed under stall");
endmodule
`default_nettype wire

// ===== verif/aesd_tb_if.sv =====
// ---------------------------------------------------------------------------
// AES-128 decrypt testbench channel notes
// The channel interfaces live with the design; this file holds the
// testbench pipeline depth constant used by the stimulus.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package aesd_tb_pkg;
   localparam int unsigned PipeDepth = 11;
endpackage

// ===== verif/aesd_checker.sv =====
// ---------------------------------------------------------------------------
// AES-128 decrypt checker
// Watches key writes and ciphertext transactions, computes the expected
// plaintext with an independent inverse cipher, and compares each result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module aesd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic [63:0] req_cipher_upper,
   input logic [63:0] req_cipher_lower,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [63:0] rsp_plain_upper,
   input logic [63:0] rsp_plain_lower,
   input logic csr_valid,
   input logic csr_ready,
   input aesd_pkg::csr_idx_type csr_index,
   input logic [63:0] csr_data,
   output int fail_count,
   output int pending_count
);
   logic [127:0] cipher_key;
   logic [127:0] plain_queue [$];

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= x;
         x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
      end
      return acc;
   endfunction

   function automatic logic [7:0] ginv(input logic [7:0] a);
      logic [7:0] r;
      r = 8'h01;
      for (int i = 0; i < 254; i++) r = gmul(r, a);
      return r;
   endfunction

   function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
      return (v << n) | (v >> (8 - n));
   endfunction

   function automatic logic [7:0] fwd_sub(input logic [7:0] v);
      logic [7:0] b;
      b = ginv(v);
      return b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
   endfunction

   logic [7:0] inv_table [256];
   logic [7:0] fwd_table [256];
   initial begin
      for (int v = 0; v < 256; v++) begin
         fwd_table[v] = fwd_sub(8'(v));
         inv_table[v] = ginv(rol8(8'(v), 1) ^ rol8(8'(v), 3) ^ rol8(8'(v), 6) ^ 8'h05);
      end
   end

   function automatic logic [127:0] decrypt_block(input logic [127:0] key,
                                                   input logic [127:0] cipher);
      logic [31:0] w [44];
      logic [7:0] rk [11][16];
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [31:0] tmp;
      logic [7:0] rcon;
      logic [127:0] plain;
      rcon = 8'h01;
      for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
      for (int i = 4; i < 44; i++) begin
         tmp = w[i-1];
         if (i % 4 == 0) begin
            tmp = {tmp[23:0], tmp[31:24]};
            tmp = {fwd_table[tmp[31:24]] ^ rcon, fwd_table[tmp[23:16]],
                   fwd_table[tmp[15:8]], fwd_table[tmp[7:0]]};
            rcon = gmul(rcon, 8'h02);
         end
         w[i] = w[i-4] ^ tmp;
      end
      for (int r = 0; r < 11; r++)
         for (int j = 0; j < 16; j++) rk[r][j] = w[4*r + j/4][31-8*(j%4) -: 8];
      for (int j = 0; j < 16; j++) s[j] = cipher[127-8*j -: 8] ^ rk[10][j];
      for (int rnd = 9; rnd >= 0; rnd--) begin
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               t[r + 4*c] = inv_table[s[r + 4*((c - r + 4) % 4)]] ^ rk[rnd][r + 4*c];
         if (rnd > 0) begin
            for (int c = 0; c < 4; c++) begin
               s[4*c] = gmul(t[4*c], 8'd14) ^ gmul(t[4*c+1], 8'd11)
                        ^ gmul(t[4*c+2], 8'd13) ^ gmul(t[4*c+3], 8'd9);
               s[4*c+1] = gmul(t[4*c], 8'd9) ^ gmul(t[4*c+1], 8'd14)
                          ^ gmul(t[4*c+2], 8'd11) ^ gmul(t[4*c+3], 8'd13);
               s[4*c+2] = gmul(t[4*c], 8'd13) ^ gmul(t[4*c+1], 8'd9)
                          ^ gmul(t[4*c+2], 8'd14) ^ gmul(t[4*c+3], 8'd11);
               s[4*c+3] = gmul(t[4*c], 8'd11) ^ gmul(t[4*c+1], 8'd13)
                          ^ gmul(t[4*c+2], 8'd9) ^ gmul(t[4*c+3], 8'd14);
            end
         end else begin
            s = t;
         end
      end
      for (int j = 0; j < 16; j++) plain[127-8*j -: 8] = s[j];
      return plain;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      logic [127:0] want;
      if (reset) begin
         cipher_key <= '0;
         fail_count = 0;
      end else begin
         // blocks accepted on the same edge as a key write use the old key
         if (req_valid && req_ready)
            plain_queue.push_back(decrypt_block(cipher_key,
                                                {req_cipher_upper, req_cipher_lower}));
         if (csr_valid && csr_ready) begin
            if (csr_index == aesd_pkg::CsrKeyUpper) cipher_key[127:64] <= csr_data;
            else if (csr_index == aesd_pkg::CsrKeyLower) cipher_key[63:0] <= csr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (plain_queue.size() == 0) begin
               $display("%0t unexpected result %h_%h", $realtime, rsp_plain_upper,
                        rsp_plain_lower);
               fail_count++;
            end else begin
               want = plain_queue.pop_front();
               if (rsp_plain_upper !== want[127:64])
                  report_mismatch("plain_upper", rsp_plain_upper, want[127:64]);
               if (rsp_plain_lower !== want[63:0])
                  report_mismatch("plain_lower", rsp_plain_lower, want[63:0]);
            end
         end
      end
      pending_count <= plain_queue.size();
   end
endmodule

// ===== verif/aes128_block_decrypt_tb.sv =====
// ---------------------------------------------------------------------------
// AES-128 decrypt testbench
// Drives key writes and ciphertext blocks with bursty traffic and output
// stalls; the checker predicts each plaintext and counts mismatches.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module aes128_block_decrypt_tb;
   logic clock;
   logic reset;
   int fail_count;
   int pending_count;
   bit hold_rsp;
   bit done;

   aesd_req_if req_chan ();
   aesd_rsp_if rsp_chan ();
   aesd_csr_if csr_chan ();

   aes128_block_decrypt dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   aesd_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_ready(req_chan.ready),
      .req_cipher_upper(req_chan.cipher_upper), .req_cipher_lower(req_chan.cipher_lower),
      .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
      .rsp_plain_upper(rsp_chan.plain_upper), .rsp_plain_lower(rsp_chan.plain_lower),
      .csr_valid(csr_chan.valid), .csr_ready(csr_chan.ready),
      .csr_index(csr_chan.index), .csr_data(csr_chan.data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // receiver: random stall pattern, plus a long hold-off on request
   initial begin
      int mode;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         mode = (done || hold_rsp) ? 0 : $urandom_range(0, 9);
         if (hold_rsp) rsp_chan.ready <= 1'b0;
         else if (mode < 3) rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         else rsp_chan.ready <= 1'b1;
      end
   end

   task automatic write_key(input aesd_pkg::csr_idx_type idx, input logic [63:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic send_block(input logic [63:0] upper, input logic [63:0] lower);
      req_chan.valid <= 1'b1;
      req_chan.cipher_upper <= upper;
      req_chan.cipher_lower <= lower;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic pause_sender(input int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // step one edge first so the last accepted transaction is counted
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (aesd_tb_pkg::PipeDepth + 2) @(posedge clock);
   endtask

   task automatic random_burst_run(input int count);
      int burst;
      burst = 0;
      for (int n = 0; n < count; n++) begin
         if (burst == 0) begin
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
            burst = $urandom_range(1, 20);
         end
         burst--;
         send_block(rand64(), rand64());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.cipher_upper = '0;
      req_chan.cipher_lower = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = aesd_pkg::CsrKeyUpper;
      csr_chan.data = '0;
      hold_rsp = 1'b0;
      done = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset key, field extremes, sparse and alternating bit patterns
      send_block('0, '0);
      send_block('1, '1);
      send_block(64'h8000000000000000, 64'h0000000000000001);
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
      send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
      drain();
      write_key(aesd_pkg::CsrKeyUpper, '1);
      write_key(aesd_pkg::CsrKeyLower, '1);
      send_block('0, '0);
      send_block('1, '1);
      send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
      drain();
      write_key(aesd_pkg::CsrKeyUpper, 64'h0001020304050607);
      write_key(aesd_pkg::CsrKeyLower, 64'h08090a0b0c0d0e0f);
      // the FIPS-197 example block
      send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
      send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
      drain();
      // out-of-range register index: ignored
      write_key(aesd_pkg::csr_idx_type'(2), rand64());
      write_key(aesd_pkg::csr_idx_type'(8'hff), '1);
      send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
      drain();

      // stall the output long enough to back up the pipeline
      hold_rsp = 1'b1;
      fork
         repeat (60) @(posedge clock);
         random_burst_run(30);
      join_any
      hold_rsp = 1'b0;
      wait fork;
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_key(aesd_pkg::CsrKeyUpper, '0);
               write_key(aesd_pkg::CsrKeyLower, '0);
            end
            1: write_key(aesd_pkg::CsrKeyLower, '1);
            default: begin
               write_key(aesd_pkg::CsrKeyUpper, rand64());
               write_key(aesd_pkg::CsrKeyLower, rand64());
            end
         endcase
         random_burst_run(150);
         drain();
      end

      done = 1'b1;
      drain();
      if (fail_count == 0 && pending_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end
endmodule
